/* rtl/bct_pkg.sv */
// shared types, codes and constants of the 8088 bus cycle target
package bct_pkg;

    // default address widths of the two stores
    localparam int MEM_ADDR_BITS_DEF = 20;
    localparam int IO_ADDR_BITS_DEF  = 16;

    // fixed field widths
    localparam int ADDR_W    = 20;
    localparam int BYTE_W    = 8;
    localparam int FUNC_W    = 4;
    localparam int WAIT_W    = 3;
    localparam int PORT_W    = 16;
    localparam int CNT_W     = 16;
    localparam int BANK_BITS = 3;
    localparam int NUM_BANKS = 1 << BANK_BITS;

    // stream and register bus widths
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 16;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // bus cycle kinds
    typedef enum logic [FUNC_W-1:0] {
        FN_MEM_RD    = 4'd0,
        FN_MEM_WR    = 4'd1,
        FN_IO_RD     = 4'd2,
        FN_IO_WR     = 4'd3,
        FN_INTACK    = 4'd4,
        FN_HOST_MEM  = 4'd5,
        FN_HOST_IO   = 4'd6,
        FN_TIMER_IRQ = 4'd7,
        FN_KEY_IRQ   = 4'd8
    } func_t;

    // interrupt vectors
    localparam logic [BYTE_W-1:0] VEC_TIMER = 8'h08;
    localparam logic [BYTE_W-1:0] VEC_KEY   = 8'h09;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_ROM_BASE   = 3'd0;
    localparam logic [2:0] REG_ROM_TOP    = 3'd1;
    localparam logic [2:0] REG_CKPT_PORT  = 3'd2;
    localparam logic [2:0] REG_WAIT_PORT  = 3'd3;
    localparam logic [2:0] REG_STATS_CTRL = 3'd4;
    localparam logic [2:0] REG_STATS_BASE = 3'd5;

    // register reset values
    localparam logic [ADDR_W-1:0] ROM_BASE_RST   = 20'hF0000;
    localparam logic [ADDR_W-1:0] ROM_TOP_RST    = 20'hFFFFF;
    localparam logic [PORT_W-1:0] CKPT_PORT_RST  = 16'h0080;
    localparam logic [PORT_W-1:0] WAIT_PORT_RST  = 16'h00E1;
    localparam logic [PORT_W-1:0] STATS_CTRL_RST = 16'h00E2;
    localparam logic [PORT_W-1:0] STATS_BASE_RST = 16'h00E3;

    // configuration seen by the datapath
    typedef struct packed {
        logic [ADDR_W-1:0] rom_base;
        logic [ADDR_W-1:0] rom_top;
        logic [PORT_W-1:0] ckpt_port;
        logic [PORT_W-1:0] wait_port;
        logic [PORT_W-1:0] stats_ctrl_port;
        logic [PORT_W-1:0] stats_base_port;
    } cfg_t;

endpackage

/* rtl/bct_ram.sv */
// single port write, single port read memory with registered read data
module bct_ram #(
    parameter int ADDR_BITS = 8,
    parameter int DATA_BITS = 8
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [DATA_BITS-1:0] wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [DATA_BITS-1:0] rdata
);

    logic [DATA_BITS-1:0] mem_reg [1 << ADDR_BITS];
    logic [DATA_BITS-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // read port, old data on a same-address write
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/bct_cfg.sv */
// register bank behind the apb port
module bct_cfg import bct_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rom_base        <= ROM_BASE_RST;
            cfg_reg.rom_top         <= ROM_TOP_RST;
            cfg_reg.ckpt_port       <= CKPT_PORT_RST;
            cfg_reg.wait_port       <= WAIT_PORT_RST;
            cfg_reg.stats_ctrl_port <= STATS_CTRL_RST;
            cfg_reg.stats_base_port <= STATS_BASE_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_ROM_BASE:   cfg_reg.rom_base        <= pwdata[ADDR_W-1:0];
                REG_ROM_TOP:    cfg_reg.rom_top         <= pwdata[ADDR_W-1:0];
                REG_CKPT_PORT:  cfg_reg.ckpt_port       <= pwdata[PORT_W-1:0];
                REG_WAIT_PORT:  cfg_reg.wait_port       <= pwdata[PORT_W-1:0];
                REG_STATS_CTRL: cfg_reg.stats_ctrl_port <= pwdata[PORT_W-1:0];
                REG_STATS_BASE: cfg_reg.stats_base_port <= pwdata[PORT_W-1:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (reg_idx)
            REG_ROM_BASE:   prdata = APB_DATA_W'(cfg_reg.rom_base);
            REG_ROM_TOP:    prdata = APB_DATA_W'(cfg_reg.rom_top);
            REG_CKPT_PORT:  prdata = APB_DATA_W'(cfg_reg.ckpt_port);
            REG_WAIT_PORT:  prdata = APB_DATA_W'(cfg_reg.wait_port);
            REG_STATS_CTRL: prdata = APB_DATA_W'(cfg_reg.stats_ctrl_port);
            REG_STATS_BASE: prdata = APB_DATA_W'(cfg_reg.stats_base_port);
            default:        prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/bus_cycle_target_8088.sv */
// 8088 bus cycle target: one decoded bus cycle or host event in, one response out.
// Takes one request per clock while s_tready is high; it drops when the response
// stalls, during the clearing pass and while the wait-state entry moves. Memory
// read and stage register load at the accept edge; the response goes from the stage
// register into the output register. Main memory is one 2^MEM_ADDR_BITS byte RAM;
// the I/O space is eight RAM banks interleaved on the low port bits, so a stats
// window read refreshes its counter bytes at once, save the one at the wait-state
// port, whose entry is held in a flop. After reset the I/O banks are cleared one
// row per cycle over all 2^(IO_ADDR_BITS-3) rows (8192 at the default width), with
// s_tready low. After a wait_port write s_tready stays low while the entry moves
// to its new port. Main memory is not cleared: read only what the host has loaded.
module bus_cycle_target_8088 import bct_pkg::*; #(
    parameter int MEM_ADDR_BITS = MEM_ADDR_BITS_DEF,
    parameter int IO_ADDR_BITS  = IO_ADDR_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // request: bus_address [19:0], write_data [27:20], zero [31:28]
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // request: func [3:0]
    input  logic [FUNC_W-1:0]     s_tuser,
    // response: read_data [7:0], data_driven [8], wait_count [11:9], intr_line [12],
    // checkpoint_pulse [13], write_dropped [14], zero [15]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int ROW_BITS = IO_ADDR_BITS - BANK_BITS;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_RUN,
        ST_FLUSH,
        ST_LOAD
    } state_t;

    cfg_t cfg;

    bct_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    state_t                  state_reg;
    logic [ROW_BITS-1:0]     clr_cnt_reg;

    // stage register
    logic                    s1_valid_reg;
    logic [FUNC_W-1:0]       s1_func_reg;
    logic [ADDR_W-1:0]       s1_addr_reg;
    logic [BYTE_W-1:0]       s1_data_reg;

    // output register
    logic                    m_tvalid_reg;
    logic [BYTE_W-1:0]       rd_reg;
    logic                    drv_reg;
    logic [WAIT_W-1:0]       ws_reg;
    logic                    intr_reg;
    logic                    pulse_reg;
    logic                    drop_reg;

    // block state
    logic [WAIT_W-1:0]       wait_reg, wait_next;
    logic [CNT_W-1:0]        mr_cnt_reg, mr_cnt_next;
    logic [CNT_W-1:0]        mw_cnt_reg, mw_cnt_next;
    logic [CNT_W-1:0]        ir_cnt_reg, ir_cnt_next;
    logic [CNT_W-1:0]        iw_cnt_reg, iw_cnt_next;
    logic                    timer_reg, timer_next;
    logic                    key_reg, key_next;
    logic [BYTE_W-1:0]       shadow_reg, shadow_next;
    logic [IO_ADDR_BITS-1:0] shadow_port_reg;

    // forwarding of a write made at the accept edge
    logic                    mem_fwd_hit_reg;
    logic [BYTE_W-1:0]       mem_fwd_data_reg;
    logic                    io_fwd_hit_reg;
    logic [BYTE_W-1:0]       io_fwd_data_reg;

    // request fields
    logic [ADDR_W-1:0]        in_addr;
    logic [BYTE_W-1:0]        in_wdata;
    logic [IO_ADDR_BITS-1:0]  in_port;
    logic                     accept;
    logic                     s1_adv;
    logic                     port_synced;

    assign in_addr  = s_tdata[ADDR_W-1:0];
    assign in_wdata = s_tdata[ADDR_W+BYTE_W-1:ADDR_W];
    assign in_port  = in_addr[IO_ADDR_BITS-1:0];

    // handshake
    assign s1_adv      = s1_valid_reg & (~m_tvalid_reg | m_tready);
    assign port_synced = (cfg.wait_port[IO_ADDR_BITS-1:0] == shadow_port_reg);
    assign s_tready    = (state_reg == ST_RUN) & port_synced & (~s1_valid_reg | s1_adv);
    assign accept      = s_tvalid & s_tready;

    // stage decode
    logic [MEM_ADDR_BITS-1:0] s1_maddr;
    logic [ADDR_W-1:0]        s1_maddr_ext;
    logic [IO_ADDR_BITS-1:0]  s1_port;
    logic [PORT_W-1:0]        s1_port_ext;
    logic [IO_ADDR_BITS-1:0]  wait_port_io;
    logic [IO_ADDR_BITS-1:0]  base_io;
    logic [IO_ADDR_BITS-1:0]  win_off;
    logic                     in_window;
    logic [BYTE_W-1:0]        stats_bytes [NUM_BANKS];

    assign s1_maddr     = s1_addr_reg[MEM_ADDR_BITS-1:0];
    assign s1_maddr_ext = ADDR_W'(s1_maddr);
    assign s1_port      = s1_addr_reg[IO_ADDR_BITS-1:0];
    assign s1_port_ext  = PORT_W'(s1_port);
    assign wait_port_io = cfg.wait_port[IO_ADDR_BITS-1:0];
    assign base_io      = cfg.stats_base_port[IO_ADDR_BITS-1:0];
    assign win_off      = s1_port - base_io;
    assign in_window    = (win_off[IO_ADDR_BITS-1:BANK_BITS] == '0);

    // counter bytes as the stats window shows them
    assign stats_bytes[0] = mr_cnt_reg[7:0];
    assign stats_bytes[1] = mr_cnt_reg[15:8];
    assign stats_bytes[2] = mw_cnt_reg[7:0];
    assign stats_bytes[3] = mw_cnt_reg[15:8];
    assign stats_bytes[4] = ir_cnt_reg[7:0];
    assign stats_bytes[5] = ir_cnt_reg[15:8];
    assign stats_bytes[6] = iw_cnt_reg[7:0];
    assign stats_bytes[7] = iw_cnt_reg[15:8];

    // main memory
    logic                     mem_we;
    logic [BYTE_W-1:0]        mem_rdata;
    logic                     mem_we_item;

    assign mem_we = mem_we_item & s1_adv;

    bct_ram #(
        .ADDR_BITS (MEM_ADDR_BITS),
        .DATA_BITS (BYTE_W)
    ) u_main_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (s1_maddr),
        .wdata (s1_data_reg),
        .re    (accept),
        .raddr (in_addr[MEM_ADDR_BITS-1:0]),
        .rdata (mem_rdata)
    );

    // io banks
    logic                     bank_we    [NUM_BANKS];
    logic [ROW_BITS-1:0]      bank_wrow  [NUM_BANKS];
    logic [BYTE_W-1:0]        bank_wdata [NUM_BANKS];
    logic [BYTE_W-1:0]        bank_rdata [NUM_BANKS];
    logic [IO_ADDR_BITS-1:0]  rd_port;
    logic                     bank_re;
    logic                     refresh_en;
    logic                     io_wr_en;
    logic                     item_refresh;
    logic                     item_io_wr;

    assign rd_port      = (state_reg == ST_FLUSH) ? wait_port_io : in_port;
    assign bank_re      = accept | (state_reg == ST_FLUSH);
    assign item_refresh = refresh_en & s1_adv;
    assign item_io_wr   = io_wr_en & s1_adv;

    for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
        logic [BANK_BITS-1:0]    slot_idx;
        logic [IO_ADDR_BITS-1:0] slot_port;

        // window slot that lands in this bank
        assign slot_idx  = BANK_BITS'(b) - base_io[BANK_BITS-1:0];
        assign slot_port = base_io + IO_ADDR_BITS'(slot_idx);

        // write port select: clear pass, shadow flush, or the stage item
        always_comb begin
            bank_we[b]    = 1'b0;
            bank_wrow[b]  = s1_port[IO_ADDR_BITS-1:BANK_BITS];
            bank_wdata[b] = s1_data_reg;
            case (state_reg)
                ST_CLEAR: begin
                    bank_we[b]    = 1'b1;
                    bank_wrow[b]  = clr_cnt_reg;
                    bank_wdata[b] = '0;
                end
                ST_FLUSH: begin
                    bank_we[b]    = (shadow_port_reg[BANK_BITS-1:0] == BANK_BITS'(b));
                    bank_wrow[b]  = shadow_port_reg[IO_ADDR_BITS-1:BANK_BITS];
                    bank_wdata[b] = shadow_reg;
                end
                ST_RUN: begin
                    if (item_refresh) begin
                        bank_we[b]    = (slot_port != wait_port_io);
                        bank_wrow[b]  = slot_port[IO_ADDR_BITS-1:BANK_BITS];
                        bank_wdata[b] = stats_bytes[slot_idx];
                    end else if (item_io_wr) begin
                        bank_we[b]    = (s1_port[BANK_BITS-1:0] == BANK_BITS'(b));
                    end
                end
                default: ;
            endcase
        end

        bct_ram #(
            .ADDR_BITS (ROW_BITS),
            .DATA_BITS (BYTE_W)
        ) u_io_bank (
            .aclk  (aclk),
            .we    (bank_we[b]),
            .waddr (bank_wrow[b]),
            .wdata (bank_wdata[b]),
            .re    (bank_re),
            .raddr (rd_port[IO_ADDR_BITS-1:BANK_BITS]),
            .rdata (bank_rdata[b])
        );
    end

    // same-edge write checks for the request being taken
    logic [BANK_BITS-1:0] in_bank;
    logic                 mem_fwd_hit;
    logic                 io_fwd_hit;

    assign in_bank     = in_port[BANK_BITS-1:0];
    assign mem_fwd_hit = mem_we & (s1_maddr == in_addr[MEM_ADDR_BITS-1:0]);
    assign io_fwd_hit  = bank_we[in_bank]
                       & (bank_wrow[in_bank] == in_port[IO_ADDR_BITS-1:BANK_BITS]);

    // stored byte seen by the stage item
    logic [BYTE_W-1:0] mem_rd_val;
    logic [BYTE_W-1:0] io_rd_val;

    assign mem_rd_val = mem_fwd_hit_reg ? mem_fwd_data_reg : mem_rdata;
    assign io_rd_val  = io_fwd_hit_reg ? io_fwd_data_reg : bank_rdata[s1_port[BANK_BITS-1:0]];

    // response and next state for the stage item
    logic [BYTE_W-1:0] rd_next;
    logic              drv_next;
    logic [WAIT_W-1:0] ws_next;
    logic              pulse_next;
    logic              drop_next;

    always_comb begin
        rd_next     = '0;
        drv_next    = 1'b0;
        ws_next     = '0;
        pulse_next  = 1'b0;
        drop_next   = 1'b0;
        wait_next   = wait_reg;
        mr_cnt_next = mr_cnt_reg;
        mw_cnt_next = mw_cnt_reg;
        ir_cnt_next = ir_cnt_reg;
        iw_cnt_next = iw_cnt_reg;
        timer_next  = timer_reg;
        key_next    = key_reg;
        shadow_next = shadow_reg;
        mem_we_item = 1'b0;
        io_wr_en    = 1'b0;
        refresh_en  = 1'b0;
        case (s1_func_reg)
            FN_MEM_RD: begin
                ws_next     = wait_reg;
                rd_next     = mem_rd_val;
                drv_next    = 1'b1;
                mr_cnt_next = mr_cnt_reg + 16'd1;
            end
            FN_MEM_WR: begin
                ws_next = wait_reg;
                if (s1_maddr_ext >= cfg.rom_base && s1_maddr_ext <= cfg.rom_top) begin
                    drop_next = 1'b1;
                end else begin
                    mem_we_item = 1'b1;
                end
                mw_cnt_next = mw_cnt_reg + 16'd1;
            end
            FN_IO_RD: begin
                ws_next  = wait_reg;
                drv_next = 1'b1;
                if (in_window) begin
                    // counters copied into the window, then the wait setting
                    refresh_en  = 1'b1;
                    shadow_next = BYTE_W'(wait_reg);
                    rd_next     = (s1_port == wait_port_io) ? BYTE_W'(wait_reg)
                                                            : stats_bytes[win_off[BANK_BITS-1:0]];
                end else if (s1_port == wait_port_io) begin
                    rd_next = shadow_reg;
                end else begin
                    rd_next = io_rd_val;
                end
                ir_cnt_next = ir_cnt_reg + 16'd1;
            end
            FN_IO_WR: begin
                ws_next     = wait_reg;
                iw_cnt_next = iw_cnt_reg + 16'd1;
                if (s1_port_ext == cfg.ckpt_port) begin
                    pulse_next = 1'b1;
                    if (s1_port == wait_port_io) begin
                        shadow_next = s1_data_reg;
                    end else begin
                        io_wr_en = 1'b1;
                    end
                end else if (s1_port_ext == cfg.wait_port) begin
                    wait_next   = s1_data_reg[WAIT_W-1:0];
                    shadow_next = BYTE_W'(s1_data_reg[WAIT_W-1:0]);
                end else if (s1_port_ext == cfg.stats_ctrl_port) begin
                    // zero clears, and this write is then the first one counted
                    if (s1_data_reg == '0) begin
                        mr_cnt_next = '0;
                        mw_cnt_next = '0;
                        ir_cnt_next = '0;
                        iw_cnt_next = 16'd1;
                    end
                end else if (s1_port == wait_port_io) begin
                    shadow_next = s1_data_reg;
                end else begin
                    io_wr_en = 1'b1;
                end
            end
            FN_INTACK: begin
                if (timer_reg) begin
                    rd_next    = VEC_TIMER;
                    drv_next   = 1'b1;
                    timer_next = 1'b0;
                end else if (key_reg) begin
                    rd_next  = VEC_KEY;
                    drv_next = 1'b1;
                    key_next = 1'b0;
                end
            end
            FN_HOST_MEM: begin
                mem_we_item = 1'b1;
            end
            FN_HOST_IO: begin
                if (s1_port == wait_port_io) begin
                    shadow_next = s1_data_reg;
                end else begin
                    io_wr_en = 1'b1;
                end
            end
            FN_TIMER_IRQ: begin
                timer_next = 1'b1;
            end
            FN_KEY_IRQ: begin
                key_next = 1'b1;
            end
            default: ;
        endcase
    end

    // control, state and output registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            s1_valid_reg    <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            wait_reg        <= '0;
            mr_cnt_reg      <= '0;
            mw_cnt_reg      <= '0;
            ir_cnt_reg      <= '0;
            iw_cnt_reg      <= '0;
            timer_reg       <= 1'b0;
            key_reg         <= 1'b0;
            shadow_reg      <= '0;
            shadow_port_reg <= WAIT_PORT_RST[IO_ADDR_BITS-1:0];
        end else begin
            case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (&clr_cnt_reg) begin
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (!s1_valid_reg && !port_synced) begin
                        state_reg <= ST_FLUSH;
                    end
                end
                ST_FLUSH: begin
                    state_reg <= ST_LOAD;
                end
                ST_LOAD: begin
                    shadow_reg      <= bank_rdata[wait_port_io[BANK_BITS-1:0]];
                    shadow_port_reg <= wait_port_io;
                    state_reg       <= ST_RUN;
                end
                default: begin
                    state_reg <= ST_CLEAR;
                end
            endcase

            // stage valid
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end

            // output valid
            if (s1_adv) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            // block state moves with each finished item
            if (s1_adv) begin
                wait_reg   <= wait_next;
                mr_cnt_reg <= mr_cnt_next;
                mw_cnt_reg <= mw_cnt_next;
                ir_cnt_reg <= ir_cnt_next;
                iw_cnt_reg <= iw_cnt_next;
                timer_reg  <= timer_next;
                key_reg    <= key_next;
                shadow_reg <= shadow_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_func_reg      <= s_tuser;
            s1_addr_reg      <= in_addr;
            s1_data_reg      <= in_wdata;
            mem_fwd_hit_reg  <= mem_fwd_hit;
            mem_fwd_data_reg <= s1_data_reg;
            io_fwd_hit_reg   <= io_fwd_hit;
            io_fwd_data_reg  <= bank_wdata[in_bank];
        end
        if (s1_adv) begin
            rd_reg    <= rd_next;
            drv_reg   <= drv_next;
            ws_reg    <= ws_next;
            intr_reg  <= timer_next | key_next;
            pulse_reg <= pulse_next;
            drop_reg  <= drop_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, drop_reg, pulse_reg, intr_reg, ws_reg, drv_reg, rd_reg};

endmodule

/* rtl/bct_checker.sv */
// port-level checks of the bus cycle target, bound to the top level
module bct_checker import bct_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // a stalled response holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("response changed while stalled");

    // a dropped write never drives data
    a_drop_no_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[14] && m_tdata[8]))
        else $error("dropped write with data driven");

    // a checkpoint write neither drives data nor flags a dropped write
    a_ckpt_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[13] |-> !m_tdata[8] && !m_tdata[14])
        else $error("checkpoint pulse with other flags");

    // reset empties the output and starts the clearing pass
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("request taken or response shown right after reset");

endmodule

bind bus_cycle_target_8088 bct_checker u_bct_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
